>>> design/atla_pkg.sv
// Package for the async track lane allocator.
// Holds shared sizes, codes, and controller/datapath command and status types.
package atla_pkg;

  localparam int NumSets     = 16;
  localparam int LanesPerSet = 16;
  localparam int NestBits    = 16;
  localparam int SetW        = $clog2(NumSets);
  localparam int LaneW       = $clog2(LanesPerSet);
  localparam int CntW        = $clog2(LanesPerSet + 1);
  localparam int AddrW       = $clog2(NumSets * LanesPerSet);
  localparam logic [NestBits-1:0] NestMax = {NestBits{1'b1}};

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_END    = 2'd1,
    OP_SCOPED = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNNESTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_RESULT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the input word and its set's lane count
    logic scan;       // check the lane just read and read the next one
    logic finish;     // decide, write back, and form the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;       // the scan has found its lane, run out of lanes, or has no lane work
  } stat_t;

endpackage

>>> design/atla_if.sv
// Valid/ready channel interfaces for the lane allocator.
// Imports atla_pkg, though the field widths are written as literals.
interface atla_in_if import atla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         set_index;
  logic signed [63:0] cookie;
  logic signed [63:0] start_time;
  logic [62:0]        duration;
  modport source (output valid, opcode, set_index, cookie, start_time, duration,
                  input ready);
  modport sink (input valid, opcode, set_index, cookie, start_time, duration,
                output ready);
endinterface

interface atla_out_if import atla_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  lane;
  logic        lane_is_new;
  logic [1:0]  status;
  logic [15:0] nest_level;
  modport source (output valid, lane, lane_is_new, status, nest_level, input ready);
  modport sink (input valid, lane, lane_is_new, status, nest_level, output ready);
endinterface

>>> design/async_track_lane_allocator.sv
// Top level of the async track lane allocator.
// Depends on atla_pkg, atla_if, atla_ctrl and atla_dp.

// The allocator takes one event word at a time and returns one result word
// per event; a new event word is accepted only after the previous result word
// has been taken. An event reads the lanes already opened in its set, one lane
// entry per clock through the lane memory, and stops at the first usable lane.
// A begin or end looks for its cookie while remembering the first idle cookie
// lane, so one pass serves both searches; a scoped slice looks for a timestamp
// lane that has ended. The scan reads at most LanesPerSet lane entries (none
// for an opcode with no lane work); the finish state then writes back and
// registers the result word, which the result state holds until it is taken,
// and the block then returns to idle. The user must write the unnestable mask
// through cfg_we_i/cfg_wdata_i only while idle; the block itself has no check.
module async_track_lane_allocator import atla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  atla_in_if.sink     in_if,
  atla_out_if.source  out_if
);

  logic [15:0] mask_q;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  atla_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  atla_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mask_i        (mask_q),
    .opcode_i      (in_if.opcode),
    .set_index_i   (in_if.set_index),
    .cookie_i      (in_if.cookie),
    .start_time_i  (in_if.start_time),
    .duration_i    (in_if.duration),
    .lane_o        (out_if.lane),
    .lane_is_new_o (out_if.lane_is_new),
    .status_o      (out_if.status),
    .nest_level_o  (out_if.nest_level)
  );

  // The block never accepts while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("accept while result pending");

  // A full status carries a zero lane.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status == ST_FULL) |-> (out_if.lane == '0 &&
    !out_if.lane_is_new)) else $error("full result with lane");

  // An accepted word leads to a busy controller next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready) else $error("not busy");

endmodule

>>> design/atla_ctrl.sv
// Controller state machine of the lane allocator.
// Depends on atla_pkg; drives the datapath through cmd_t and reads stat_t.
module atla_ctrl import atla_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   if (stat_i.done) state_d = S_FINISH;
      S_FINISH: state_d = S_RESULT;
      S_RESULT: if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN:   cmd_o.scan = 1'b1;
      S_FINISH: cmd_o.finish = 1'b1;
      S_RESULT: out_valid_o = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

>>> design/atla_dp.sv
// Datapath of the lane allocator: lane memory, lane counts, scan, update.
// Depends on atla_pkg; controlled by atla_ctrl through cmd_t and stat_t.
module atla_dp import atla_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [15:0]        mask_i,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         set_index_i,
  input  logic [63:0]        cookie_i,
  input  logic [63:0]        start_time_i,
  input  logic [62:0]        duration_i,
  output logic [3:0]         lane_o,
  output logic               lane_is_new_o,
  output logic [1:0]         status_o,
  output logic [15:0]        nest_level_o
);

  // Lane entry: kind, cookie, nest count, end time, in one memory word.
  typedef struct packed {
    logic                kind;
    logic [63:0]         cookie;
    logic [NestBits-1:0] nest;
    logic [63:0]         end_t;
  } entry_t;

  entry_t mem [NumSets*LanesPerSet];
  logic [CntW-1:0] used_q [NumSets];

  logic [1:0]          op_q;
  logic [SetW-1:0]     set_q;
  logic [63:0]         cookie_q, start_q, end_sum_q;
  logic                unnest_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     ptr_q;       // next lane to read
  entry_t              rd_q;
  logic [LaneW-1:0]    rd_idx_q;    // lane held in rd_q
  logic                rd_vld_q;
  logic                found_q;
  logic [LaneW-1:0]    pick_q;
  logic [NestBits-1:0] pick_nest_q;
  logic                free_q;      // an idle cookie lane has been seen
  logic [LaneW-1:0]    free_idx_q;

  logic [3:0]  lane_q;
  logic        new_q;
  logic [1:0]  status_q;
  logic [15:0] nest_q;

  logic [SetW-1:0] in_set;
  logic [63:0]     sum_w;
  logic [63:0]     end_sum_d;
  assign in_set    = SetW'(set_index_i % NumSets);
  assign sum_w     = start_time_i + {1'b0, duration_i};
  assign end_sum_d = (!start_time_i[63] && sum_w[63]) ? {1'b0, {63{1'b1}}} : sum_w;

  logic is_scoped, is_none;
  assign is_scoped = (op_q == OP_SCOPED);
  assign is_none   = (op_q == OP_NONE);

  // Tests on the entry read in the previous cycle.
  logic match_hit, free_hit;
  always_comb begin
    match_hit = 1'b0;
    free_hit  = 1'b0;
    if (rd_vld_q) begin
      if (is_scoped) begin
        match_hit = rd_q.kind && ($signed(rd_q.end_t) <= $signed(start_q));
      end else begin
        match_hit = !rd_q.kind && (rd_q.cookie == cookie_q);
        free_hit  = !rd_q.kind && (rd_q.nest == '0);
      end
    end
  end

  logic rd_en;
  assign rd_en       = cmd_i.scan && !match_hit && !is_none && (ptr_q < cnt_q);
  assign stat_o.done = is_none || match_hit || (ptr_q >= cnt_q);

  logic [AddrW-1:0] rd_addr;
  assign rd_addr = AddrW'({set_q, ptr_q[LaneW-1:0]});

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_idx_q <= ptr_q[LaneW-1:0];
    end
  end

  // Final decision, from the registered scan outcome.
  logic                fresh;
  logic                full;
  logic [LaneW-1:0]    fin_pick;
  logic [NestBits-1:0] n_old, n_new;
  entry_t              wr_e;
  always_comb begin
    fresh    = 1'b0;
    fin_pick = pick_q;
    n_old    = pick_nest_q;
    if (!found_q) begin
      n_old = '0;
      if (!is_scoped && free_q) begin
        fin_pick = free_idx_q;
      end else begin
        fresh    = 1'b1;
        fin_pick = cnt_q[LaneW-1:0];
      end
    end
    full  = fresh && (cnt_q >= CntW'(LanesPerSet));
    n_new = n_old;
    if (op_q == OP_BEGIN) begin
      if (unnest_q) n_new = NestBits'(1);
      else if (n_old != NestMax) n_new = n_old + 1'b1;
    end else if (op_q == OP_END && n_old != '0) begin
      n_new = n_old - 1'b1;
    end
    wr_e.kind   = is_scoped;
    wr_e.cookie = cookie_q;
    wr_e.nest   = is_scoped ? '0 : n_new;
    wr_e.end_t  = end_sum_q;
  end

  logic wr_en;
  assign wr_en = cmd_i.finish && !is_none && !full;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AddrW'({set_q, fin_pick})] <= wr_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSets; s++) used_q[s] <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ptr_q    <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
        free_q   <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= rd_en;
        if (rd_en) ptr_q <= ptr_q + 1'b1;
        if (match_hit) found_q <= 1'b1;
        if (free_hit) free_q <= 1'b1;
      end
      if (wr_en && fresh) used_q[set_q] <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && match_hit) begin
      pick_q      <= rd_idx_q;
      pick_nest_q <= rd_q.nest;
    end
    if (cmd_i.scan && free_hit && !free_q) free_idx_q <= rd_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= opcode_i;
      set_q     <= in_set;
      cookie_q  <= cookie_i;
      start_q   <= start_time_i;
      end_sum_q <= end_sum_d;
      unnest_q  <= mask_i[in_set];
      cnt_q     <= used_q[in_set];
    end
    if (cmd_i.finish) begin
      if (is_none || full) begin
        lane_q   <= '0;
        new_q    <= 1'b0;
        status_q <= is_none ? ST_OK : ST_FULL;
        nest_q   <= '0;
      end else begin
        lane_q   <= 4'(fin_pick);
        new_q    <= fresh;
        status_q <= (is_scoped && unnest_q) ? ST_UNNESTED : ST_OK;
        nest_q   <= is_scoped ? '0 : 16'(n_new);
      end
    end
  end

  assign lane_o        = lane_q;
  assign lane_is_new_o = new_q;
  assign status_o      = status_q;
  assign nest_level_o  = nest_q;

endmodule
